[rtl/kar_pkg.sv]
// Shared types and constants of the key auto-repeat generator.
package kar_pkg;

  // Horizontal and vertical caps on moves emitted by one tick.
  localparam int MaxShifts = 32;
  localparam int MaxDrops  = 32;

  // Time arithmetic.
  localparam int TimeBits  = 24;
  localparam int TimerBits = 25;
  localparam int FieldBits = 24;

  // Move counter: wide enough to hold the larger cap itself.
  localparam int CapMax = (MaxShifts > MaxDrops) ? MaxShifts : MaxDrops;
  localparam int CntBits = $clog2(CapMax + 1);

  localparam int CfgIdxBits = 2;

  typedef enum logic [1:0] {
    KindPress      = 2'd0,
    KindRelease    = 2'd1,
    KindReleaseAll = 2'd2,
    KindTick       = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    KeyLeft  = 2'd0,
    KeyRight = 2'd1,
    KeyDown  = 2'd2,
    KeyOther = 2'd3
  } key_e;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxBits-1:0] RegRepeatDelay    = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegRepeatInterval = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegDropPeriod     = 2'd2;

  // Owner codes of the horizontal repeat.
  localparam logic [1:0] OwnerNone  = 2'd0;
  localparam logic [1:0] OwnerLeft  = 2'd1;
  localparam logic [1:0] OwnerRight = 2'd2;

  typedef logic [TimerBits-1:0] timer_t;

endpackage

[rtl/kar_ifs.sv]
// Request channels of the key auto-repeat generator: key/tick input, move output, config.

interface kar_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [1:0]                    which_key;
  logic [kar_pkg::FieldBits-1:0] elapsed;

  modport source (output valid, kind, which_key, elapsed, input ready);
  modport sink   (input valid, kind, which_key, elapsed, output ready);
endinterface

interface kar_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       last;

  modport source (output valid, action, last, input ready);
  modport sink   (input valid, action, last, output ready);
endinterface

interface kar_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [kar_pkg::CfgIdxBits-1:0] index;
  logic [kar_pkg::FieldBits-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/kar_alu.sv]
// Shared timer unit: saturating add or compare-and-subtract on 25-bit time values.
module kar_alu (
  input  kar_pkg::timer_t a_i,
  input  kar_pkg::timer_t b_i,
  input  logic            sub_i,
  output kar_pkg::timer_t res_o,
  output logic            ge_o
);
  import kar_pkg::*;

  logic [TimerBits:0] sum;
  logic [TimerBits:0] diff;

  assign sum  = {1'b0, a_i} + {1'b0, b_i};
  assign diff = {1'b0, a_i} - {1'b0, b_i};

  // In add mode the carry out saturates the result to all ones.
  always_comb begin
    if (sub_i) begin
      res_o = diff[TimerBits-1:0];
    end else if (sum[TimerBits]) begin
      res_o = '1;
    end else begin
      res_o = sum[TimerBits-1:0];
    end
  end

  assign ge_o = ~diff[TimerBits];

endmodule

[rtl/key_auto_repeat_generator_core.sv]
// Top level of the key auto-repeat generator for the left, right and down keys.

// The block takes one request at a time on in_i: a press, a release, a
// release of all keys, or a time tick that carries the elapsed time. Key
// requests only update the held keys, their timers and repeat flags and
// the owner of the horizontal repeat, and produce nothing on out_o. A tick
// adds the elapsed time to the owner's timer, if any, and to the down
// timer while down is held with a nonzero drop period, and emits the
// resulting moves on out_o one per request, horizontal moves first, then
// down moves, with last set on the final move of the tick; a tick with no
// moves produces nothing. A tick emits at most 64 moves. The sequencer
// steps the single shared add/compare-subtract unit through the saturating
// adds and the repeated subtractions one per cycle, waiting while out_o
// stalls. The input is not ready while a tick is in progress. The
// configuration port cfg_i is always ready and should be written only
// while the block is idle; writes to an index beyond the three registers
// are ignored.
module key_auto_repeat_generator_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  kar_in_if.sink        in_i,
  kar_out_if.source     out_o,
  kar_cfg_if.sink       cfg_i
);
  import kar_pkg::*;

  // Sequencer states.
  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StHAdd   = 3'd1;
  localparam logic [2:0] StHDelay = 3'd2;
  localparam logic [2:0] StHRep   = 3'd3;
  localparam logic [2:0] StDAdd   = 3'd4;
  localparam logic [2:0] StDRep   = 3'd5;
  localparam logic [2:0] StFlush  = 3'd6;

  localparam logic [CntBits-1:0] ShiftCap = CntBits'(MaxShifts);
  localparam logic [CntBits-1:0] DropCap  = CntBits'(MaxDrops);

  // Configuration registers.
  logic [TimeBits-1:0] delay_q, interval_q, period_q;

  // Key state.
  logic   left_held_q, left_held_d, right_held_q, right_held_d;
  logic   down_held_q, down_held_d;
  logic   left_rep_q, left_rep_d, right_rep_q, right_rep_d;
  timer_t left_timer_q, left_timer_d, right_timer_q, right_timer_d;
  timer_t down_timer_q, down_timer_d;
  logic [1:0] owner_q, owner_d;

  // Sequencer and working registers.
  logic [2:0]          state_q, state_d;
  timer_t              work_q, work_d;
  logic [CntBits-1:0]  count_q, count_d;
  logic [TimeBits-1:0] dt_q, dt_d;

  // One move held back until we know whether another follows it.
  logic pend_valid_q, pend_valid_d;
  key_e pend_act_q, pend_act_d;

  // Output register.
  logic out_valid_q, out_valid_d;
  key_e out_act_q, out_act_d;
  logic out_last_q, out_last_d;

  // Shared unit controls.
  timer_t alu_a, alu_b, alu_res;
  logic   alu_sub, alu_ge;

  logic   in_acc, out_free, emit_ok, emit, push, push_last;
  key_e   emit_act, push_act, own_act;
  logic   own_rep;
  timer_t own_timer;
  logic   set_own_timer, set_own_rep;
  timer_t own_timer_new;

  assign in_i.ready  = (state_q == StIdle);
  assign in_acc      = in_i.valid & in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid  = out_valid_q;
  assign out_o.action = out_act_q;
  assign out_o.last   = out_last_q;

  assign out_free = ~out_valid_q | out_o.ready;
  assign emit_ok  = ~pend_valid_q | out_free;

  // The owner is left or right whenever the horizontal states run.
  assign own_rep   = (owner_q == OwnerLeft) ? left_rep_q : right_rep_q;
  assign own_timer = (owner_q == OwnerLeft) ? left_timer_q : right_timer_q;
  assign own_act   = (owner_q == OwnerLeft) ? KeyLeft : KeyRight;

  // Operand selection for the shared unit: adds in the two add states,
  // compare-and-subtract against the running work value elsewhere.
  always_comb begin
    alu_sub = 1'b1;
    alu_a   = work_q;
    alu_b   = '0;
    unique case (state_q)
      StHAdd: begin
        alu_sub = 1'b0;
        alu_a   = own_timer;
        alu_b   = TimerBits'(dt_q);
      end
      StDAdd: begin
        alu_sub = 1'b0;
        alu_a   = down_timer_q;
        alu_b   = TimerBits'(dt_q);
      end
      StHDelay: alu_b = TimerBits'(delay_q);
      StHRep:   alu_b = TimerBits'(interval_q);
      StDRep:   alu_b = TimerBits'(period_q);
      default:  alu_b = '0;
    endcase
  end

  kar_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res),
    .ge_o  (alu_ge)
  );

  always_comb begin
    left_held_d   = left_held_q;
    right_held_d  = right_held_q;
    down_held_d   = down_held_q;
    left_rep_d    = left_rep_q;
    right_rep_d   = right_rep_q;
    left_timer_d  = left_timer_q;
    right_timer_d = right_timer_q;
    down_timer_d  = down_timer_q;
    owner_d       = owner_q;
    state_d       = state_q;
    work_d        = work_q;
    count_d       = count_q;
    dt_d          = dt_q;
    pend_valid_d  = pend_valid_q;
    pend_act_d    = pend_act_q;
    emit          = 1'b0;
    emit_act      = own_act;
    push          = 1'b0;
    push_act      = pend_act_q;
    push_last     = 1'b0;
    set_own_timer = 1'b0;
    set_own_rep   = 1'b0;
    own_timer_new = work_q;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          unique case (kind_e'(in_i.kind))
            KindPress: begin
              unique case (key_e'(in_i.which_key))
                KeyLeft: begin
                  left_held_d  = 1'b1;
                  left_rep_d   = 1'b0;
                  left_timer_d = '0;
                  owner_d      = OwnerLeft;
                end
                KeyRight: begin
                  right_held_d  = 1'b1;
                  right_rep_d   = 1'b0;
                  right_timer_d = '0;
                  owner_d       = OwnerRight;
                end
                KeyDown: begin
                  down_held_d  = 1'b1;
                  down_timer_d = '0;
                end
                default: ;
              endcase
            end
            KindRelease: begin
              unique case (key_e'(in_i.which_key))
                KeyLeft: begin
                  left_held_d  = 1'b0;
                  left_rep_d   = 1'b0;
                  left_timer_d = '0;
                  if (owner_q == OwnerLeft) begin
                    if (right_held_q) begin
                      owner_d       = OwnerRight;
                      right_rep_d   = 1'b0;
                      right_timer_d = '0;
                    end else begin
                      owner_d = OwnerNone;
                    end
                  end
                end
                KeyRight: begin
                  right_held_d  = 1'b0;
                  right_rep_d   = 1'b0;
                  right_timer_d = '0;
                  if (owner_q == OwnerRight) begin
                    if (left_held_q) begin
                      owner_d      = OwnerLeft;
                      left_rep_d   = 1'b0;
                      left_timer_d = '0;
                    end else begin
                      owner_d = OwnerNone;
                    end
                  end
                end
                KeyDown: begin
                  down_held_d  = 1'b0;
                  down_timer_d = '0;
                end
                default: ;
              endcase
            end
            KindReleaseAll: begin
              left_held_d   = 1'b0;
              left_rep_d    = 1'b0;
              left_timer_d  = '0;
              right_held_d  = 1'b0;
              right_rep_d   = 1'b0;
              right_timer_d = '0;
              down_held_d   = 1'b0;
              down_timer_d  = '0;
              owner_d       = OwnerNone;
            end
            KindTick: begin
              dt_d    = in_i.elapsed[TimeBits-1:0];
              count_d = '0;
              if (owner_q == OwnerLeft || owner_q == OwnerRight) begin
                state_d = StHAdd;
              end else begin
                state_d = StDAdd;
              end
            end
            default: ;
          endcase
        end
      end

      StHAdd: begin
        work_d  = alu_res;
        state_d = own_rep ? StHRep : StHDelay;
      end

      // The initial delay has to pass before the first move.
      StHDelay: begin
        if (alu_ge) begin
          if (emit_ok) begin
            emit        = 1'b1;
            set_own_rep = 1'b1;
            work_d      = alu_res;
            count_d     = CntBits'(1);
            state_d     = StHRep;
          end
        end else begin
          set_own_timer = 1'b1;
          own_timer_new = work_q;
          state_d       = StDAdd;
        end
      end

      // One repeat per cycle while out_o takes the moves; a zero interval repeats up to the cap.
      StHRep: begin
        if (count_q == ShiftCap) begin
          set_own_timer = 1'b1;
          own_timer_new = '0;
          state_d       = StDAdd;
        end else if (interval_q == '0) begin
          if (emit_ok) begin
            emit    = 1'b1;
            count_d = count_q + CntBits'(1);
          end
        end else if (alu_ge) begin
          if (emit_ok) begin
            emit    = 1'b1;
            work_d  = alu_res;
            count_d = count_q + CntBits'(1);
          end
        end else begin
          set_own_timer = 1'b1;
          own_timer_new = work_q;
          state_d       = StDAdd;
        end
      end

      StDAdd: begin
        count_d = '0;
        if (down_held_q && period_q != '0) begin
          work_d  = alu_res;
          state_d = StDRep;
        end else begin
          state_d = StFlush;
        end
      end

      StDRep: begin
        emit_act = KeyDown;
        if (count_q == DropCap) begin
          down_timer_d = '0;
          state_d      = StFlush;
        end else if (alu_ge) begin
          if (emit_ok) begin
            emit    = 1'b1;
            work_d  = alu_res;
            count_d = count_q + CntBits'(1);
          end
        end else begin
          down_timer_d = work_q;
          state_d      = StFlush;
        end
      end

      // The held-back move is the final one of the tick.
      StFlush: begin
        if (pend_valid_q) begin
          if (out_free) begin
            push         = 1'b1;
            push_last    = 1'b1;
            pend_valid_d = 1'b0;
            state_d      = StIdle;
          end
        end else begin
          state_d = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase

    if (set_own_timer) begin
      if (owner_q == OwnerLeft) begin
        left_timer_d = own_timer_new;
      end else begin
        right_timer_d = own_timer_new;
      end
    end
    if (set_own_rep) begin
      if (owner_q == OwnerLeft) begin
        left_rep_d = 1'b1;
      end else begin
        right_rep_d = 1'b1;
      end
    end

    // A new move releases the one held back, which is then not the last.
    if (emit) begin
      if (pend_valid_q) begin
        push = 1'b1;
      end
      pend_valid_d = 1'b1;
      pend_act_d   = emit_act;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_act_d   = out_act_q;
    out_last_d  = out_last_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_act_d   = push_act;
      out_last_d  = push_last;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q       <= '0;
      interval_q    <= '0;
      period_q      <= '0;
      left_held_q   <= 1'b0;
      right_held_q  <= 1'b0;
      down_held_q   <= 1'b0;
      left_rep_q    <= 1'b0;
      right_rep_q   <= 1'b0;
      left_timer_q  <= '0;
      right_timer_q <= '0;
      down_timer_q  <= '0;
      owner_q       <= OwnerNone;
      state_q       <= StIdle;
      count_q       <= '0;
      pend_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          RegRepeatDelay:    delay_q    <= cfg_i.data[TimeBits-1:0];
          RegRepeatInterval: interval_q <= cfg_i.data[TimeBits-1:0];
          RegDropPeriod:     period_q   <= cfg_i.data[TimeBits-1:0];
          default: ;
        endcase
      end
      left_held_q   <= left_held_d;
      right_held_q  <= right_held_d;
      down_held_q   <= down_held_d;
      left_rep_q    <= left_rep_d;
      right_rep_q   <= right_rep_d;
      left_timer_q  <= left_timer_d;
      right_timer_q <= right_timer_d;
      down_timer_q  <= down_timer_d;
      owner_q       <= owner_d;
      state_q       <= state_d;
      count_q       <= count_d;
      pend_valid_q  <= pend_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    work_q     <= work_d;
    dt_q       <= dt_d;
    pend_act_q <= pend_act_d;
    out_act_q  <= out_act_d;
    out_last_q <= out_last_d;
  end

endmodule
